// ----- hw/rtl/ipid_pkg.sv -----
`timescale 1ns / 1ps
package ipid_pkg;

	// field widths
	localparam int unsigned LevelW   = 16;
	localparam int unsigned TimeW    = 32;
	localparam int unsigned LimitW   = 15;
	localparam int unsigned IntervalW = 16;
	localparam int unsigned PowerW   = 15;
	localparam int unsigned GainW    = 8;
	localparam int unsigned FineW    = 23;
	localparam int unsigned SumW     = 32;
	localparam int unsigned FracW    = 8;

	// derivative gain: raw * 10 * (200 / interval)
	localparam int unsigned DerivNum  = 200;
	localparam int unsigned DerivMul  = 10;
	localparam int unsigned QuoW      = 8;
	localparam int unsigned KdW       = 19;

	// configuration port
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// register reset values
	localparam logic [LimitW-1:0]    MaxErrorRst    = 15'd32767;
	localparam logic [LimitW-1:0]    MaxErrorSumRst = 15'd32767;
	localparam logic [IntervalW-1:0] IntervalRst    = 16'd100;
	localparam logic [PowerW-1:0]    MaxPowerRst    = 15'd255;
	localparam logic [GainW-1:0]     GainRst        = 8'd0;

	typedef enum logic [CfgIdxW-1:0] {
		RegMaxError     = 3'd0,
		RegMaxErrorSum  = 3'd1,
		RegIntervalMs   = 3'd2,
		RegMaxPower     = 3'd3,
		RegPropGainRaw  = 3'd4,
		RegIntegGainRaw = 3'd5,
		RegDerivGainRaw = 3'd6
	} reg_idx_t;

	// settings seen by the datapath
	typedef struct packed {
		logic [LimitW-1:0]    max_error;
		logic [LimitW-1:0]    max_error_sum;
		logic [IntervalW-1:0] interval_ms;
		logic [PowerW-1:0]    max_power;
		logic [GainW-1:0]     prop_gain;
		logic [GainW-1:0]     integ_gain;
		logic [KdW-1:0]       kd;
	} cfg_t;

endpackage

// ----- hw/rtl/ipid_in_if.sv -----
`timescale 1ns / 1ps
interface ipid_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] target;
	logic signed [15:0] measured;
	logic [31:0]        now_ms;

	modport source (output valid, target, measured, now_ms, input ready);
	modport sink (input valid, target, measured, now_ms, output ready);
endinterface

// ----- hw/rtl/ipid_out_if.sv -----
`timescale 1ns / 1ps
interface ipid_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] power;
	logic        updated;

	modport source (output valid, power, updated, input ready);
	modport sink (input valid, power, updated, output ready);
endinterface

// ----- hw/rtl/ipid_cfg.sv -----
`timescale 1ns / 1ps
module ipid_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [ipid_pkg::CfgIdxW-1:0]  index,
	input  logic [ipid_pkg::CfgDataW-1:0] data,
	output ipid_pkg::cfg_t                cfg,
	output logic                          busy
);
	import ipid_pkg::*;

	localparam int unsigned CntW = $clog2(QuoW);

	typedef enum logic [1:0] {
		GainIdle,
		GainDivide,
		GainScale
	} gain_state_t;

	logic [LimitW-1:0]    max_error_q;
	logic [LimitW-1:0]    max_error_sum_q;
	logic [IntervalW-1:0] interval_q;
	logic [PowerW-1:0]    max_power_q;
	logic [GainW-1:0]     prop_gain_q;
	logic [GainW-1:0]     integ_gain_q;
	logic [GainW-1:0]     deriv_gain_q;

	gain_state_t          state_q;
	logic [CntW-1:0]      cnt_q;
	logic [IntervalW-1:0] rem_q;
	logic [QuoW-1:0]      dvd_q;
	logic [QuoW-1:0]      quo_q;
	logic [KdW-1:0]       kd_q;

	logic                 restart;
	logic [IntervalW:0]   trial;
	logic                 fits;
	logic [QuoW-1:0]      quo_final;
	logic [2*GainW-1:0]   kd_base;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_error_q     <= MaxErrorRst;
			max_error_sum_q <= MaxErrorSumRst;
			interval_q      <= IntervalRst;
			max_power_q     <= MaxPowerRst;
			prop_gain_q     <= GainRst;
			integ_gain_q    <= GainRst;
			deriv_gain_q    <= GainRst;
		end else if (we) begin
			unique case (reg_idx_t'(index))
				RegMaxError:     max_error_q     <= data[LimitW-1:0];
				RegMaxErrorSum:  max_error_sum_q <= data[LimitW-1:0];
				RegIntervalMs:   interval_q      <= data[IntervalW-1:0];
				RegMaxPower:     max_power_q     <= data[PowerW-1:0];
				RegPropGainRaw:  prop_gain_q     <= data[GainW-1:0];
				RegIntegGainRaw: integ_gain_q    <= data[GainW-1:0];
				RegDerivGainRaw: deriv_gain_q    <= data[GainW-1:0];
				default: ;
			endcase
		end
	end

	// a new interval or derivative gain reloads the derivative gain
	assign restart = we && ((reg_idx_t'(index) == RegIntervalMs) ||
		(reg_idx_t'(index) == RegDerivGainRaw));

	// restoring division step: one quotient bit per cycle
	assign trial     = {rem_q, dvd_q[QuoW-1]};
	assign fits      = trial >= {1'b0, interval_q};
	assign quo_final = (interval_q == '0) ? '0 : quo_q;
	assign kd_base   = deriv_gain_q * quo_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GainIdle;
			cnt_q   <= '0;
			rem_q   <= '0;
			dvd_q   <= '0;
			quo_q   <= '0;
			kd_q    <= '0;
		end else if (restart) begin
			state_q <= GainDivide;
			cnt_q   <= '0;
			rem_q   <= '0;
			dvd_q   <= QuoW'(DerivNum);
			quo_q   <= '0;
		end else begin
			unique case (state_q)
				GainIdle: ;
				GainDivide: begin
					rem_q <= fits ? IntervalW'(trial - {1'b0, interval_q})
						: trial[IntervalW-1:0];
					quo_q <= {quo_q[QuoW-2:0], fits};
					dvd_q <= {dvd_q[QuoW-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(QuoW - 1)) begin
						state_q <= GainScale;
					end
				end
				GainScale: begin
					// times ten as times eight plus times two
					kd_q    <= KdW'({kd_base, 3'b000}) + KdW'({kd_base, 1'b0});
					state_q <= GainIdle;
				end
				default: state_q <= GainIdle;
			endcase
		end
	end

	assign busy = state_q != GainIdle;

	assign cfg.max_error     = max_error_q;
	assign cfg.max_error_sum = max_error_sum_q;
	assign cfg.interval_ms   = interval_q;
	assign cfg.max_power     = max_power_q;
	assign cfg.prop_gain     = prop_gain_q;
	assign cfg.integ_gain    = integ_gain_q;
	assign cfg.kd            = kd_q;

endmodule

// ----- hw/rtl/ipid_core.sv -----
`timescale 1ns / 1ps
module ipid_core (
	input  logic              clk,
	input  logic              arst_n,
	input  ipid_pkg::cfg_t    cfg,
	input  logic              hold,
	ipid_in_if.sink           in_ch,
	ipid_out_if.source        out_ch
);
	import ipid_pkg::*;

	localparam int unsigned ProdPW = 27;
	localparam int unsigned ProdIW = 24;
	localparam int unsigned ProdDW = 36;
	localparam int unsigned AccW   = 38;

	// input register
	logic                     valid_s1;
	logic signed [LevelW-1:0] target_s1;
	logic signed [LevelW-1:0] measured_s1;
	logic [TimeW-1:0]         now_s1;

	// output register
	logic                     valid_s2;
	logic [PowerW-1:0]        power_s2;
	logic                     updated_s2;

	// controller state
	logic [FineW-1:0]         fine_q;
	logic signed [SumW-1:0]   err_sum_q;
	logic signed [LevelW-1:0] prev_err_q;
	logic [TimeW-1:0]         last_ms_q;

	logic                     advance;
	logic                     accept;
	logic                     zero_target;
	logic                     due;
	logic [TimeW-1:0]         elapsed;
	logic signed [LevelW:0]   err_raw;
	logic signed [LevelW:0]   lim_e;
	logic signed [LevelW:0]   err_c;
	logic signed [LevelW-1:0] err;
	logic signed [LevelW:0]   dlt;
	logic signed [SumW:0]     sum_raw;
	logic signed [SumW-1:0]   sum_sat;
	logic signed [SumW+1:0]   isum_raw;
	logic signed [SumW+1:0]   lim_i;
	logic signed [SumW+1:0]   isum_c;
	logic signed [LevelW-1:0] isum;
	logic [GainW+2:0]         kp5;
	logic signed [ProdPW-1:0] prod_p;
	logic signed [ProdIW-1:0] prod_i;
	logic signed [ProdDW-1:0] prod_d;
	logic signed [AccW-1:0]   y;
	logic signed [AccW-1:0]   fine_diff;
	logic [FineW-1:0]         fine_max;
	logic [FineW-1:0]         fine_new;

	// handshake
	assign advance      = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready  = !hold && (!valid_s1 || advance);
	assign accept       = in_ch.valid && in_ch.ready;

	// update decision
	assign zero_target = target_s1 == '0;
	assign elapsed     = now_s1 - last_ms_q;
	assign due         = elapsed > {{(TimeW-IntervalW){1'b0}}, cfg.interval_ms};

	// error, running sum and integral operand
	always_comb begin
		err_raw = measured_s1 - target_s1;
		lim_e   = signed'({2'b00, cfg.max_error});
		if (err_raw > lim_e) begin
			err_c = lim_e;
		end else if (err_raw < -lim_e) begin
			err_c = -lim_e;
		end else begin
			err_c = err_raw;
		end
		err = err_c[LevelW-1:0];
		dlt = err - prev_err_q;

		sum_raw = err_sum_q + err;
		if (sum_raw[SumW] != sum_raw[SumW-1]) begin
			sum_sat = sum_raw[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
		end else begin
			sum_sat = sum_raw[SumW-1:0];
		end

		isum_raw = sum_sat + err;
		lim_i    = signed'({{(SumW+2-LimitW){1'b0}}, cfg.max_error_sum});
		if (isum_raw > lim_i) begin
			isum_c = lim_i;
		end else if (isum_raw < -lim_i) begin
			isum_c = -lim_i;
		end else begin
			isum_c = isum_raw;
		end
		isum = isum_c[LevelW-1:0];
	end

	// gain products and accumulator update
	always_comb begin
		kp5    = {1'b0, cfg.prop_gain, 2'b00} + {3'b000, cfg.prop_gain};
		prod_p = signed'({1'b0, kp5}) * err;
		prod_i = signed'({1'b0, cfg.integ_gain}) * isum;
		prod_d = signed'({1'b0, cfg.kd}) * dlt;
		y      = prod_p + prod_i + prod_d;

		fine_diff = signed'({{(AccW-FineW){1'b0}}, fine_q}) - y;
		fine_max  = {cfg.max_power, {FracW{1'b0}}};
		if (fine_diff < 0) begin
			fine_new = '0;
		end else if (fine_diff > signed'({{(AccW-FineW){1'b0}}, fine_max})) begin
			fine_new = fine_max;
		end else begin
			fine_new = fine_diff[FineW-1:0];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_s1   <= in_ch.target;
			measured_s1 <= in_ch.measured;
			now_s1      <= in_ch.now_ms;
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q     <= '0;
			err_sum_q  <= '0;
			prev_err_q <= '0;
			last_ms_q  <= '0;
		end else if (advance) begin
			if (zero_target) begin
				fine_q <= '0;
			end else if (due) begin
				fine_q     <= fine_new;
				err_sum_q  <= sum_sat;
				prev_err_q <= err;
				last_ms_q  <= now_s1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (zero_target) begin
				power_s2 <= '0;
			end else if (due) begin
				power_s2 <= fine_new[FineW-1:FracW];
			end else begin
				power_s2 <= fine_q[FineW-1:FracW];
			end
			updated_s2 <= !zero_target && due;
		end
	end

	assign out_ch.valid   = valid_s2;
	assign out_ch.power   = power_s2;
	assign out_ch.updated = updated_s2;

endmodule

// ----- hw/rtl/incremental_pid_speed_regulator.sv -----
`timescale 1ns / 1ps
// Incremental PID speed regulator
//
// in_ch carries one beat per control sample: target, measured and the
// free-running millisecond stamp now_ms. out_ch returns exactly one beat per
// input beat, in order: power (accumulator >> 8) and updated, set when the
// sample ran a PID update. A zero target forces power to zero at once.
// cfg_we/cfg_index/cfg_data write the seven settings; write them only while
// no beat is in flight.
// Throughput: one beat per cycle while out_ch does not stall and no register
// write or gain reload holds in_ch.ready low. An accepted input beat moves
// from the input register into the output register when out_ch is free; the
// whole update is one pass of logic between the input and output registers.
// A write to interval_ms or deriv_gain_raw reloads the derivative gain
// 10 * raw * (200 / interval_ms) through a bit-serial divider: in_ch.ready
// stays low while it forms the 8 quotient bits and then scales the result.
// Reset clears the accumulator, error sum, last error and last update time,
// loads the register defaults and empties both stages.
// When out_ch stalls, one more beat is held in the input register; after that
// in_ch.ready drops until the output beat is taken.
module incremental_pid_speed_regulator (
	input  logic                          clk,
	input  logic                          arst_n,
	ipid_in_if.sink                       in_ch,
	ipid_out_if.source                    out_ch,
	input  logic                          cfg_we,
	input  logic [ipid_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [ipid_pkg::CfgDataW-1:0] cfg_data
);
	import ipid_pkg::*;

	cfg_t cfg;
	logic gain_busy;
	logic hold;

	ipid_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg),
		.busy   (gain_busy)
	);

	// no new beat while the gain reloads or a setting is written
	assign hold = gain_busy || cfg_we;

	ipid_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.hold   (hold),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

// ----- hw/rtl/ipid_checker.sv -----
`timescale 1ns / 1ps
module ipid_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [ipid_pkg::PowerW-1:0]  out_power,
	input logic                         out_updated,
	input logic                         cfg_we,
	input logic [ipid_pkg::CfgIdxW-1:0] cfg_index
);
	import ipid_pkg::*;

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_power) && $stable(out_updated))
		else $error("stalled output beat changed");

	// an accepted input beat is followed by an output beat on offer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("no output beat two cycles after input beat");

	// no input beat alongside a register write
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_ready)
		else $error("input accepted during register write");

	// gain reload holds off input
	a_gain_reload: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == RegIntervalMs || cfg_index == RegDerivGainRaw)
		|=> !in_ready)
		else $error("input accepted while derivative gain reloads");

endmodule

bind incremental_pid_speed_regulator ipid_checker u_ipid_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_power   (out_ch.power),
	.out_updated (out_ch.updated),
	.cfg_we      (cfg_we),
	.cfg_index   (cfg_index)
);
